### sv/jsu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and codes for the JSON string unescaper with UTF-8 checking.
// ----------------------------------------------------------------------------
package jsu_pkg;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_CLOSE = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ERR_NONE       = 4'd0,
        ERR_NO_QUOTE   = 4'd1,
        ERR_CTRL       = 4'd2,
        ERR_BAD_LEAD   = 4'd3,
        ERR_BAD_CONT   = 4'd4,
        ERR_BAD_SCALAR = 4'd5,
        ERR_BAD_ESC    = 4'd6,
        ERR_BAD_HEX    = 4'd7,
        ERR_BAD_PAIR   = 4'd8,
        ERR_TRUNC      = 4'd9
    } err_t;

    // results caused by one source byte, data[0] goes out first
    typedef struct packed {
        logic [2:0]      count;
        logic [3:0][7:0] data;
        kind_t           kind;
        err_t            code;
    } grp_t;

endpackage
`default_nettype wire

### sv/jsu_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_in_if
// Source byte channel: valid/ready handshake with byte and end-of-source flag.
// ----------------------------------------------------------------------------
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_source;

    modport source (output valid, output in_byte, output end_of_source, input ready);
    modport sink (input valid, input in_byte, input end_of_source, output ready);
endinterface
`default_nettype wire

### sv/jsu_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_out_if
// Result channel: valid/ready handshake with decoded byte, kind and error code.
// ----------------------------------------------------------------------------
interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [3:0] error_code;
    logic       last_of_run;

    modport source (output valid, output out_byte, output kind, output error_code,
                    output last_of_run, input ready);
    modport sink (input valid, input out_byte, input kind, input error_code,
                  input last_of_run, output ready);
endinterface
`default_nettype wire

### sv/jsu_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_decode
// Parser state and per-byte decode: escapes, \u pairs, raw UTF-8 checking.
// ----------------------------------------------------------------------------
module jsu_decode
    import jsu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       take,
    input  wire logic [7:0] in_byte,
    input  wire logic       end_of_source,
    output grp_t            grp
);

    typedef enum logic [2:0] {
        M_IDLE = 3'd0,
        M_BODY = 3'd1,
        M_ESC  = 3'd2,
        M_HEX1 = 3'd3,
        M_PBS  = 3'd4,
        M_PU   = 3'd5,
        M_HEX2 = 3'd6,
        M_CONT = 3'd7
    } mode_t;

    localparam logic [7:0]  CH_QUOTE  = 8'h22;
    localparam logic [7:0]  CH_BSLASH = 8'h5c;
    localparam logic [7:0]  CH_U      = 8'h75;
    localparam logic [20:0] MAX_SCALAR = 21'h10ffff;

    mode_t       mode_reg, mode_next;
    logic [15:0] hex_reg, hex_next;
    logic [1:0]  hcnt_reg, hcnt_next;
    logic [9:0]  hoff_reg, hoff_next;
    logic [20:0] seq_reg, seq_next;
    logic [1:0]  rem_reg, rem_next;
    logic [1:0]  cls_reg, cls_next;

    logic        fault;
    logic        closed;
    err_t        code;
    logic        use_lit;
    logic [7:0]  lit;
    logic        use_enc;
    logic [20:0] enc_scalar;
    logic [20:0] sc_cat;
    logic [1:0]  rem_dec;
    logic        below_min;
    logic        hex_ok;
    logic [3:0]  hex_val;
    logic [15:0] acc;

    logic [3:0][7:0] enc_data;
    logic [2:0]      enc_len;

    always_comb
    begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        case (in_byte) inside
            [8'h30:8'h39]:                hex_val = in_byte[3:0];
            [8'h41:8'h46], [8'h61:8'h66]: hex_val = in_byte[3:0] + 4'd9;
            default:                      hex_ok  = 1'b0;
        endcase
    end

    always_comb
    begin
        mode_next  = mode_reg;
        hex_next   = hex_reg;
        hcnt_next  = hcnt_reg;
        hoff_next  = hoff_reg;
        seq_next   = seq_reg;
        rem_next   = rem_reg;
        cls_next   = cls_reg;
        fault      = 1'b0;
        closed     = 1'b0;
        code       = ERR_NONE;
        use_lit    = 1'b0;
        lit        = in_byte;
        use_enc    = 1'b0;
        enc_scalar = 21'd0;
        sc_cat     = {seq_reg[14:0], in_byte[5:0]};
        rem_dec    = rem_reg - 2'd1;
        acc        = {hex_reg[11:0], hex_val};
        case (cls_reg)
            2'd0:    below_min = sc_cat < 21'h80;
            2'd1:    below_min = sc_cat < 21'h800;
            default: below_min = sc_cat < 21'h10000;
        endcase

        case (mode_reg)
            M_BODY:
            begin
                case (in_byte) inside
                    CH_QUOTE:      closed = 1'b1;
                    [8'h00:8'h1f]:
                    begin
                        fault = 1'b1;
                        code  = ERR_CTRL;
                    end
                    CH_BSLASH:     mode_next = M_ESC;
                    [8'h20:8'h7f]: use_lit = 1'b1;
                    [8'hc2:8'hdf]:
                    begin
                        seq_next  = {16'd0, in_byte[4:0]};
                        rem_next  = 2'd1;
                        cls_next  = 2'd0;
                        mode_next = M_CONT;
                    end
                    [8'he0:8'hef]:
                    begin
                        seq_next  = {17'd0, in_byte[3:0]};
                        rem_next  = 2'd2;
                        cls_next  = 2'd1;
                        mode_next = M_CONT;
                    end
                    [8'hf0:8'hf4]:
                    begin
                        seq_next  = {18'd0, in_byte[2:0]};
                        rem_next  = 2'd3;
                        cls_next  = 2'd2;
                        mode_next = M_CONT;
                    end
                    default:
                    begin
                        fault = 1'b1;
                        code  = ERR_BAD_LEAD;
                    end
                endcase
            end
            M_CONT:
            begin
                if (in_byte[7:6] != 2'b10)
                begin
                    fault = 1'b1;
                    code  = ERR_BAD_CONT;
                end
                else
                begin
                    seq_next = sc_cat;
                    rem_next = rem_dec;
                    if (rem_dec == 2'd0)
                    begin
                        if (below_min || sc_cat > MAX_SCALAR ||
                            (sc_cat >= 21'h00d800 && sc_cat <= 21'h00dfff))
                        begin
                            fault = 1'b1;
                            code  = ERR_BAD_SCALAR;
                        end
                        else
                        begin
                            use_enc    = 1'b1;
                            enc_scalar = sc_cat;
                            mode_next  = M_BODY;
                        end
                    end
                end
            end
            M_ESC:
            begin
                mode_next = M_BODY;
                case (in_byte)
                    CH_QUOTE, CH_BSLASH, 8'h2f: use_lit = 1'b1;
                    8'h62:
                    begin
                        use_lit = 1'b1;
                        lit     = 8'h08;
                    end
                    8'h66:
                    begin
                        use_lit = 1'b1;
                        lit     = 8'h0c;
                    end
                    8'h6e:
                    begin
                        use_lit = 1'b1;
                        lit     = 8'h0a;
                    end
                    8'h72:
                    begin
                        use_lit = 1'b1;
                        lit     = 8'h0d;
                    end
                    8'h74:
                    begin
                        use_lit = 1'b1;
                        lit     = 8'h09;
                    end
                    CH_U:
                    begin
                        hcnt_next = 2'd0;
                        mode_next = M_HEX1;
                    end
                    default:
                    begin
                        fault = 1'b1;
                        code  = ERR_BAD_ESC;
                    end
                endcase
            end
            M_HEX1, M_HEX2:
            begin
                if (!hex_ok)
                begin
                    fault = 1'b1;
                    code  = ERR_BAD_HEX;
                end
                else
                begin
                    hex_next  = acc;
                    hcnt_next = hcnt_reg + 2'd1;
                    if (hcnt_reg == 2'd3)
                    begin
                        if (mode_reg == M_HEX1)
                        begin
                            if (acc >= 16'hd800 && acc <= 16'hdbff)
                            begin
                                hoff_next = acc[9:0];
                                mode_next = M_PBS;
                            end
                            else if (acc >= 16'hdc00)
                            begin
                                if (acc <= 16'hdfff)
                                begin
                                    fault = 1'b1;
                                    code  = ERR_BAD_PAIR;
                                end
                                else
                                begin
                                    use_enc    = 1'b1;
                                    enc_scalar = {5'd0, acc};
                                    mode_next  = M_BODY;
                                end
                            end
                            else
                            begin
                                use_enc    = 1'b1;
                                enc_scalar = {5'd0, acc};
                                mode_next  = M_BODY;
                            end
                        end
                        else if (acc < 16'hdc00 || acc > 16'hdfff)
                        begin
                            fault = 1'b1;
                            code  = ERR_BAD_PAIR;
                        end
                        else
                        begin
                            use_enc    = 1'b1;
                            enc_scalar = 21'h10000 + {1'b0, hoff_reg, acc[9:0]};
                            mode_next  = M_BODY;
                        end
                    end
                end
            end
            M_PBS:
            begin
                if (in_byte == CH_BSLASH)
                begin
                    mode_next = M_PU;
                end
                else
                begin
                    fault = 1'b1;
                    code  = ERR_BAD_PAIR;
                end
            end
            M_PU:
            begin
                if (in_byte == CH_U)
                begin
                    hcnt_next = 2'd0;
                    mode_next = M_HEX2;
                end
                else
                begin
                    fault = 1'b1;
                    code  = ERR_BAD_PAIR;
                end
            end
            default:
            begin
                if (in_byte == CH_QUOTE)
                begin
                    mode_next = M_BODY;
                end
                else
                begin
                    fault = 1'b1;
                    code  = ERR_NO_QUOTE;
                end
            end
        endcase

        if (fault || closed || end_of_source)
        begin
            mode_next = M_IDLE;
        end
    end

    // utf-8 encoder, scalar is known valid here
    always_comb
    begin
        enc_data = '0;
        if (enc_scalar <= 21'h7f)
        begin
            enc_len     = 3'd1;
            enc_data[0] = enc_scalar[7:0];
        end
        else if (enc_scalar <= 21'h7ff)
        begin
            enc_len     = 3'd2;
            enc_data[0] = {3'b110, enc_scalar[10:6]};
            enc_data[1] = {2'b10, enc_scalar[5:0]};
        end
        else if (enc_scalar <= 21'hffff)
        begin
            enc_len     = 3'd3;
            enc_data[0] = {4'b1110, enc_scalar[15:12]};
            enc_data[1] = {2'b10, enc_scalar[11:6]};
            enc_data[2] = {2'b10, enc_scalar[5:0]};
        end
        else
        begin
            enc_len     = 3'd4;
            enc_data[0] = {5'b11110, enc_scalar[20:18]};
            enc_data[1] = {2'b10, enc_scalar[17:12]};
            enc_data[2] = {2'b10, enc_scalar[11:6]};
            enc_data[3] = {2'b10, enc_scalar[5:0]};
        end
    end

    always_comb
    begin
        grp       = '0;
        grp.kind  = KIND_DATA;
        grp.code  = ERR_NONE;
        if (fault)
        begin
            grp.count = 3'd1;
            grp.kind  = KIND_ERROR;
            grp.code  = code;
        end
        else if (closed)
        begin
            grp.count = 3'd1;
            grp.kind  = KIND_CLOSE;
        end
        else if (end_of_source)
        begin
            grp.count = 3'd1;
            grp.kind  = KIND_ERROR;
            grp.code  = ERR_TRUNC;
        end
        else if (use_lit)
        begin
            grp.count   = 3'd1;
            grp.data[0] = lit;
        end
        else if (use_enc)
        begin
            grp.count = enc_len;
            grp.data  = enc_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            hex_reg  <= '0;
            hcnt_reg <= '0;
            hoff_reg <= '0;
            seq_reg  <= '0;
            rem_reg  <= '0;
            cls_reg  <= '0;
        end
        else if (take)
        begin
            mode_reg <= mode_next;
            hex_reg  <= hex_next;
            hcnt_reg <= hcnt_next;
            hoff_reg <= hoff_next;
            seq_reg  <= seq_next;
            rem_reg  <= rem_next;
            cls_reg  <= cls_next;
        end
    end

endmodule
`default_nettype wire

### sv/json_string_unescape_utf8_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_check
// Decodes a quoted JSON string byte by byte with UTF-8 validation.
// ----------------------------------------------------------------------------
// the first result is registered: it is valid in the cycle after the source byte transaction
// throughput: one source byte per cycle while each byte yields at most one
//   result and the sink is ready; a byte yielding several results holds the input
//   until the single result buffer drains, one result per cycle while the sink is ready
// reset: parser returns to idle (awaiting opening quote), result buffer empty
module json_string_unescape_utf8_check
    import jsu_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    jsu_in_if.sink    in_ch,
    jsu_out_if.source out_ch
);

    grp_t            grp;
    logic            in_fire;
    logic            out_fire;
    logic [2:0]      cnt_reg, cnt_next;
    logic [1:0]      idx_reg, idx_next;
    logic [3:0][7:0] data_reg;
    kind_t           kind_reg;
    err_t            code_reg;

    jsu_decode u_decode (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (in_fire),
        .in_byte       (in_ch.in_byte),
        .end_of_source (in_ch.end_of_source),
        .grp           (grp)
    );

    assign out_fire     = out_ch.valid && out_ch.ready;
    assign in_ch.ready  = (cnt_reg == 3'd0) || (cnt_reg == 3'd1 && out_ch.ready);
    assign in_fire      = in_ch.valid && in_ch.ready;

    assign out_ch.valid       = cnt_reg != 3'd0;
    assign out_ch.out_byte    = data_reg[idx_reg];
    assign out_ch.kind        = kind_reg;
    assign out_ch.error_code  = code_reg;
    assign out_ch.last_of_run = cnt_reg == 3'd1;

    always_comb
    begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (in_fire)
        begin
            cnt_next = grp.count;
            idx_next = 2'd0;
        end
        else if (out_fire)
        begin
            cnt_next = cnt_reg - 3'd1;
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 3'd0;
            idx_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            data_reg <= grp.data;
            kind_reg <= grp.kind;
            code_reg <= grp.code;
        end
    end

    // a close or error result stands alone
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.kind != KIND_DATA |-> out_ch.last_of_run)
        else $error("non-data result not last of run");

    // error code present exactly on error results
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> ((out_ch.kind == KIND_ERROR) == (out_ch.error_code != ERR_NONE)))
        else $error("error code does not match result kind");

    // non-data results carry a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.kind != KIND_DATA |-> out_ch.out_byte == 8'd0)
        else $error("non-data result with nonzero byte");

    // buffer empties after the last result when nothing new arrives
    assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && out_ch.last_of_run && !in_fire |=> !out_ch.valid)
        else $error("result repeated after last of run");

endmodule
`default_nettype wire

### tb/tb_json_string_unescape_utf8_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_json_string_unescape_utf8_check
// Self-checking bench for the JSON string unescaper. Source bytes go in over
// a valid/ready channel with random gaps; a built-in decoder predicts every
// result, and each result transaction is checked field by field in order.
// Directed strings hit the field extremes and a full surrogate pair escape.
// Random strings follow: mostly well-formed with escapes and raw UTF-8,
// plus faults, cut-off input and noise. Back-pressure and drain pauses are
// exercised along the way.
// ----------------------------------------------------------------------------
module tb_json_string_unescape_utf8_check;
    import jsu_pkg::*;

    localparam int HOLD_CYCLES = 150;
    localparam int WD_LIMIT    = 2000;
    localparam int SETTLE      = 10;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;

    // simple escapes: character after backslash and the byte it stands for
    localparam logic [7:0] ESC_IN  [8] = '{8'h22, 8'h5c, 8'h2f, 8'h62,
                                           8'h66, 8'h6e, 8'h72, 8'h74};
    localparam logic [7:0] ESC_OUT [8] = '{8'h22, 8'h5c, 8'h2f, 8'h08,
                                           8'h0c, 8'h0a, 8'h0d, 8'h09};

    typedef enum logic [3:0] {
        P_IDLE = 4'd0,
        P_BODY = 4'd1,
        P_ESC  = 4'd2,
        P_HEX1 = 4'd3,
        P_PBS  = 4'd4,
        P_PU   = 4'd5,
        P_HEX2 = 4'd6,
        P_CONT = 4'd7
    } pmode_t;

    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
        err_t       code;
        logic       last;
    } res_t;

    logic clk = 1'b0;
    logic rst_n;

    jsu_in_if  in_ch ();
    jsu_out_if out_ch ();

    json_string_unescape_utf8_check uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // decoder state
    pmode_t      pmode;
    logic [15:0] hex_acc;
    logic [1:0]  hex_cnt;
    logic [9:0]  hi_off;
    logic [20:0] seq_val;
    logic [1:0]  seq_left;
    logic [1:0]  seq_cls;

    res_t        decoded_q [$];
    logic [7:0]  src_q [$];
    int          eos_idx;

    int          fail_cnt = 0;
    int          bytes_sent = 0;
    int          n_data = 0;
    int          n_close = 0;
    int          n_err = 0;
    logic [9:0]  codes_hit = '0;
    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;
    int          hold_cnt;
    int          stall_cnt = 0;

    function automatic void add_src(input logic [7:0] b);
        src_q.insert(src_q.size(), b);
    endfunction

    function automatic void add_res(input res_t r);
        decoded_q.insert(decoded_q.size(), r);
    endfunction

    function automatic void go_idle();
        pmode    = P_IDLE;
        hex_acc  = '0;
        hex_cnt  = '0;
        hi_off   = '0;
        seq_val  = '0;
        seq_left = '0;
        seq_cls  = '0;
    endfunction

    function automatic int hex_val(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
        if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
        if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
        return -1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
        if (nib < 4'd10) return CH_ZERO + 8'(nib);
        return (upper ? CH_UA : CH_LA) + 8'(nib) - 8'd10;
    endfunction

    function automatic int utf8_encode(input logic [20:0] s, output logic [3:0][7:0] d);
        d = '0;
        if (s <= 21'h7f)
        begin
            d[0] = s[7:0];
            return 1;
        end
        if (s <= 21'h7ff)
        begin
            d[0] = {3'b110, s[10:6]};
            d[1] = {2'b10, s[5:0]};
            return 2;
        end
        if (s <= 21'hffff)
        begin
            d[0] = {4'b1110, s[15:12]};
            d[1] = {2'b10, s[11:6]};
            d[2] = {2'b10, s[5:0]};
            return 3;
        end
        d[0] = {5'b11110, s[20:18]};
        d[1] = {2'b10, s[17:12]};
        d[2] = {2'b10, s[11:6]};
        d[3] = {2'b10, s[5:0]};
        return 4;
    endfunction

    // advance the decoder by one source byte and queue the results it causes
    function automatic void unescape_byte(input logic [7:0] b, input logic eos);
        logic [3:0][7:0] d;
        int              nd;
        bit              closed;
        err_t            ec;
        int              hv;
        logic [20:0]     floor_v;
        res_t            r;
        d = '0;
        nd = 0;
        closed = 1'b0;
        ec = ERR_NONE;
        case (pmode)
            P_BODY:
            begin
                if (b == CH_QUOTE)
                    closed = 1'b1;
                else if (b < CH_SPACE)
                    ec = ERR_CTRL;
                else if (b == CH_BSLASH)
                    pmode = P_ESC;
                else if (b < 8'h80)
                begin
                    d[0] = b;
                    nd = 1;
                end
                else if (b >= 8'hc2 && b <= 8'hdf)
                begin
                    seq_val = 21'(b[4:0]);
                    seq_left = 2'd1;
                    seq_cls = 2'd0;
                    pmode = P_CONT;
                end
                else if (b >= 8'he0 && b <= 8'hef)
                begin
                    seq_val = 21'(b[3:0]);
                    seq_left = 2'd2;
                    seq_cls = 2'd1;
                    pmode = P_CONT;
                end
                else if (b >= 8'hf0 && b <= 8'hf4)
                begin
                    seq_val = 21'(b[2:0]);
                    seq_left = 2'd3;
                    seq_cls = 2'd2;
                    pmode = P_CONT;
                end
                else
                    ec = ERR_BAD_LEAD;
            end
            P_CONT:
            begin
                if (b[7:6] != 2'b10)
                    ec = ERR_BAD_CONT;
                else
                begin
                    seq_val = {seq_val[14:0], b[5:0]};
                    seq_left = seq_left - 2'd1;
                    if (seq_left == 2'd0)
                    begin
                        floor_v = (seq_cls == 2'd0) ? 21'h80 :
                                  (seq_cls == 2'd1) ? 21'h800 : 21'h10000;
                        if (seq_val < floor_v || seq_val > 21'h10ffff ||
                            (seq_val >= 21'hd800 && seq_val <= 21'hdfff))
                            ec = ERR_BAD_SCALAR;
                        else
                        begin
                            nd = utf8_encode(seq_val, d);
                            pmode = P_BODY;
                            seq_val = '0;
                            seq_cls = '0;
                        end
                    end
                end
            end
            P_ESC:
            begin
                pmode = P_BODY;
                if (b == CH_U)
                begin
                    hex_acc = '0;
                    hex_cnt = '0;
                    pmode = P_HEX1;
                end
                else
                begin
                    ec = ERR_BAD_ESC;
                    for (int i = 0; i < 8; i++)
                        if (ESC_IN[i] == b)
                        begin
                            d[0] = ESC_OUT[i];
                            nd = 1;
                            ec = ERR_NONE;
                        end
                end
            end
            P_HEX1, P_HEX2:
            begin
                hv = hex_val(b);
                if (hv < 0)
                    ec = ERR_BAD_HEX;
                else
                begin
                    hex_acc = {hex_acc[11:0], hv[3:0]};
                    if (hex_cnt < 2'd3)
                        hex_cnt = hex_cnt + 2'd1;
                    else
                    begin
                        hex_cnt = '0;
                        if (pmode == P_HEX1)
                        begin
                            if (hex_acc >= 16'hd800 && hex_acc <= 16'hdbff)
                            begin
                                hi_off = hex_acc[9:0];
                                pmode = P_PBS;
                            end
                            else if (hex_acc >= 16'hdc00 && hex_acc <= 16'hdfff)
                                ec = ERR_BAD_PAIR;
                            else
                            begin
                                nd = utf8_encode(21'(hex_acc), d);
                                pmode = P_BODY;
                            end
                        end
                        else if (hex_acc < 16'hdc00 || hex_acc > 16'hdfff)
                            ec = ERR_BAD_PAIR;
                        else
                        begin
                            nd = utf8_encode(21'h10000 + {1'b0, hi_off, hex_acc[9:0]}, d);
                            pmode = P_BODY;
                            hi_off = '0;
                        end
                        hex_acc = '0;
                    end
                end
            end
            P_PBS:
            begin
                if (b == CH_BSLASH)
                    pmode = P_PU;
                else
                    ec = ERR_BAD_PAIR;
            end
            P_PU:
            begin
                if (b == CH_U)
                begin
                    hex_acc = '0;
                    hex_cnt = '0;
                    pmode = P_HEX2;
                end
                else
                    ec = ERR_BAD_PAIR;
            end
            default:
            begin
                if (b == CH_QUOTE)
                begin
                    go_idle();
                    pmode = P_BODY;
                end
                else
                    ec = ERR_NO_QUOTE;
            end
        endcase

        // own fault first, then close, then cut-off source
        if (ec == ERR_NONE && !closed && eos)
            ec = ERR_TRUNC;
        if (ec != ERR_NONE || closed)
        begin
            go_idle();
            r.data = 8'h00;
            r.code = ec;
            r.last = 1'b1;
            if (ec != ERR_NONE)
            begin
                r.kind = KIND_ERROR;
                codes_hit[ec] = 1'b1;
            end
            else
                r.kind = KIND_CLOSE;
            add_res(r);
        end
        else
        begin
            for (int i = 0; i < nd; i++)
            begin
                r.data = d[i];
                r.kind = KIND_DATA;
                r.code = ERR_NONE;
                r.last = (i == nd - 1);
                add_res(r);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // source side
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic eos);
        if (!quiet && $urandom_range(99) < 35)
        begin
            in_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 35);
        end
        in_ch.valid         <= 1'b1;
        in_ch.in_byte       <= b;
        in_ch.end_of_source <= eos;
        do
            @(posedge clk);
        while (!in_ch.ready);
        unescape_byte(b, eos);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (decoded_q.size() != 0);
    endtask

    task automatic send_src();
        for (int i = 0; i < src_q.size() && (eos_idx < 0 || i <= eos_idx); i++)
            send_byte(src_q[i], i == eos_idx);
    endtask

    function automatic logic [7:0] cont_byte();
        return {2'b10, 6'($urandom_range(0, 63))};
    endfunction

    function automatic void push_hex4(input logic [15:0] v);
        for (int i = 3; i >= 0; i--)
            add_src(hex_char(v[i*4 +: 4], 1'($urandom_range(0, 1))));
    endfunction

    function automatic void push_u(input logic [15:0] v);
        add_src(CH_BSLASH);
        add_src(CH_U);
        push_hex4(v);
    endfunction

    function automatic void add_segment();
        logic [7:0]      c;
        logic [15:0]     v;
        logic [20:0]     s;
        logic [3:0][7:0] d;
        int              n;
        case ($urandom_range(0, 5))
            0, 1:
            begin
                do
                    c = 8'($urandom_range(8'h20, 8'h7f));
                while (c == CH_QUOTE || c == CH_BSLASH);
                add_src(c);
            end
            2:
            begin
                add_src(CH_BSLASH);
                add_src(ESC_IN[$urandom_range(0, 7)]);
            end
            3:
            begin
                if ($urandom_range(0, 2) == 0)
                    v = 16'($urandom_range(0, 8'hff));
                else
                    v = 16'($urandom_range(0, 16'hffff));
                if (v >= 16'hd800 && v <= 16'hdfff)
                    v = v ^ 16'h4000;
                push_u(v);
            end
            4:
            begin
                push_u(16'hd800 + 16'($urandom_range(0, 10'h3ff)));
                push_u(16'hdc00 + 16'($urandom_range(0, 10'h3ff)));
            end
            default:
            begin
                case ($urandom_range(0, 2))
                    0: s = 21'($urandom_range(21'h80, 21'h7ff));
                    1:
                    begin
                        s = 21'($urandom_range(21'h800, 21'hffff));
                        if (s >= 21'hd800 && s <= 21'hdfff)
                            s = s ^ 21'h4000;
                    end
                    default: s = 21'($urandom_range(21'h10000, 21'h10ffff));
                endcase
                n = utf8_encode(s, d);
                for (int i = 0; i < n; i++)
                    add_src(d[i]);
            end
        endcase
    endfunction

    function automatic void add_fault();
        logic [7:0]  c;
        logic [15:0] v;
        int          n;
        case ($urandom_range(0, 9))
            0: add_src(8'($urandom_range(0, 8'h1f)));
            1:
            begin
                if ($urandom_range(0, 1))
                    add_src(8'($urandom_range(8'h80, 8'hc1)));
                else
                    add_src(8'($urandom_range(8'hf5, 8'hff)));
            end
            2:
            begin
                add_src(8'($urandom_range(8'hc2, 8'hf4)));
                c = 8'($urandom_range(0, 255));
                if (c[7:6] == 2'b10)
                    c[6] = 1'b1;
                add_src(c);
            end
            3:
            begin
                // random lead with random continuations, valid or out of range
                c = 8'($urandom_range(8'hc2, 8'hf4));
                n = (c < 8'he0) ? 1 : (c < 8'hf0) ? 2 : 3;
                add_src(c);
                repeat (n) add_src(cont_byte());
                add_src(CH_QUOTE);
            end
            4:
            begin
                do
                    c = 8'($urandom_range(0, 255));
                while (c == CH_U || c inside {ESC_IN});
                add_src(CH_BSLASH);
                add_src(c);
            end
            5:
            begin
                add_src(CH_BSLASH);
                add_src(CH_U);
                repeat ($urandom_range(0, 3))
                    add_src(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
                do
                    c = 8'($urandom_range(0, 255));
                while (hex_val(c) >= 0);
                add_src(c);
            end
            6: push_u(16'hdc00 + 16'($urandom_range(0, 10'h3ff)));
            7:
            begin
                push_u(16'hd800 + 16'($urandom_range(0, 10'h3ff)));
                if ($urandom_range(0, 1))
                begin
                    do
                        c = 8'($urandom_range(0, 255));
                    while (c == CH_BSLASH);
                    add_src(c);
                end
                else
                begin
                    do
                        c = 8'($urandom_range(0, 255));
                    while (c == CH_U);
                    add_src(CH_BSLASH);
                    add_src(c);
                end
            end
            8:
            begin
                push_u(16'hd800 + 16'($urandom_range(0, 10'h3ff)));
                v = 16'($urandom_range(0, 16'hffff));
                if (v >= 16'hdc00 && v <= 16'hdfff)
                    v = v ^ 16'h2000;
                push_u(v);
            end
            default:
            begin
                // overlong, raw surrogate, above the last code point
                case ($urandom_range(0, 3))
                    0:
                    begin
                        add_src(8'he0);
                        add_src(8'($urandom_range(8'h80, 8'h9f)));
                    end
                    1:
                    begin
                        add_src(8'hed);
                        add_src(8'($urandom_range(8'ha0, 8'hbf)));
                    end
                    2:
                    begin
                        add_src(8'hf0);
                        add_src(8'($urandom_range(8'h80, 8'h8f)));
                        add_src(cont_byte());
                    end
                    default:
                    begin
                        add_src(8'hf4);
                        add_src(8'($urandom_range(8'h90, 8'hbf)));
                        add_src(cont_byte());
                    end
                endcase
                add_src(cont_byte());
            end
        endcase
    endfunction

    function automatic void build_string();
        int r;
        src_q.delete();
        eos_idx = -1;
        if ($urandom_range(99) < 6)
        begin
            add_src(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 3) == 0)
                eos_idx = 0;
        end
        else
        begin
            add_src(CH_QUOTE);
            repeat ($urandom_range(0, 6)) add_segment();
            if ($urandom_range(99) < 75)
                add_src(CH_QUOTE);
            else
                add_fault();
            r = $urandom_range(99);
            if (r < 12)
                eos_idx = src_q.size() - 1;
            else if (r < 20)
                eos_idx = $urandom_range(0, src_q.size() - 1);
        end
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_idle_bytes();
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
    endtask

    task automatic test_field_extremes();
        src_q = '{CH_QUOTE, 8'h20, 8'h7f, 8'hf4, 8'h8f, 8'hbf, 8'hbf, CH_QUOTE};
        eos_idx = src_q.size() - 1;
        send_src();
    endtask

    task automatic test_surrogate_escape();
        src_q.delete();
        add_src(CH_QUOTE);
        push_u(16'hdbff);
        push_u(16'hdfff);
        add_src(8'h41);
        eos_idx = src_q.size() - 1;
        send_src();
    endtask

    task automatic test_random_strings(input int n_items);
        int first;
        first = bytes_sent;
        while (bytes_sent - first < n_items)
        begin
            build_string();
            send_src();
            if ($urandom_range(99) < 5)
                wait_drained();
        end
    endtask

    task automatic test_back_to_back();
        quiet = 1'b1;
        test_random_strings(70);
        quiet = 1'b0;
    endtask

    task automatic test_output_hold();
        hold_req = 1'b1;
        test_random_strings(50);
        hold_req = 1'b0;
        wait_drained();
    endtask

    initial
    begin
        in_ch.valid         = 1'b0;
        in_ch.in_byte       = 8'h00;
        in_ch.end_of_source = 1'b0;
        rst_n               = 1'b0;
        go_idle();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_bytes();
        test_field_extremes();
        test_surrogate_escape();
        wait_drained();
        test_random_strings(260);
        test_back_to_back();
        test_output_hold();

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        $display("covered %0d source bytes, %0d results: %0d data, %0d closes, %0d errors",
                 bytes_sent, n_data + n_close + n_err, n_data, n_close, n_err);
        $display("error codes reached (bit per code): %b", codes_hit);
        if (fail_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------
    initial
    begin
        out_ch.ready = 1'b0;
        hold_cnt = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req && hold_cnt < HOLD_CYCLES)
            begin
                hold_cnt++;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                if (!hold_req)
                    hold_cnt = 0;
                out_ch.ready <= quiet || ($urandom_range(99) >= 35);
            end
        end
    end

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (decoded_q.size() == 0)
            begin
                $error("unexpected result transaction: out_byte %h kind %0d error_code %0d",
                       out_ch.out_byte, out_ch.kind, out_ch.error_code);
                fail_cnt++;
            end
            else
            begin
                want = decoded_q.pop_front();
                case (want.kind)
                    KIND_DATA:  n_data++;
                    KIND_CLOSE: n_close++;
                    default:    n_err++;
                endcase
                if (out_ch.kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, out_ch.kind);
                    fail_cnt++;
                end
                if (out_ch.error_code !== want.code)
                begin
                    $error("error_code: expected %0d, got %0d", want.code, out_ch.error_code);
                    fail_cnt++;
                end
                if (out_ch.out_byte !== want.data)
                begin
                    $error("out_byte: expected %h, got %h", want.data, out_ch.out_byte);
                    fail_cnt++;
                end
                if (out_ch.last_of_run !== want.last)
                begin
                    $error("last_of_run: expected %0d, got %0d", want.last, out_ch.last_of_run);
                    fail_cnt++;
                end
            end
        end
    end

    // no transaction on either channel for too long
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= WD_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule
